// File: hw/rtl/acs_pkg.sv
// Shared types and codes for the affinity chunk scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package acs_pkg;

	// input item operation codes
	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_THREADS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ITER  = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic item_load;   // latch requester
		logic part_div;    // start block size division, rewind partition sweep
		logic part_wr;     // write one partition entry
		logic own_rd;      // read requester's entry
		logic own_take;    // select requester's entry as source
		logic scan_init;   // clear best candidate, rewind scan
		logic scan_rd;     // read next scan entry
		logic scan_cmp;    // compare returned entry against best
		logic take_div;    // latch chunk start, start chunk size division
		logic take_wr;     // write back source entry, load grant result
		logic res_clear;   // load all-zero result
	} acs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
		logic req_in_range;
		logic own_work;
		logic scan_last;
		logic part_last;
		logic found;
	} acs_sts_t;

endpackage

// File: hw/rtl/acs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module acs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/acs_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the datapath for block and chunk sizes.
`timescale 1ns / 1ps

module acs_div #(
	parameter int DW = 17,
	parameter int VW = 5,
	localparam int CW = $clog2(DW)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/acs_datapath.sv
// Scheduler datapath: configuration registers, per-worker block table,
// shared divider, steal scan compare and result registers.
// Depends on acs_pkg, acs_ram and acs_div.
`timescale 1ns / 1ps

module acs_datapath #(
	parameter int MAX_WORKERS = 16,
	parameter int ITER_BITS   = 16,
	localparam int TW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
	localparam int NTW   = $clog2(MAX_WORKERS + 1),
	localparam int CFG_W = (ITER_BITS > NTW) ? ITER_BITS : NTW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata,
	input  logic [TW-1:0]                 requester_thread,
	input  acs_pkg::acs_cmd_t             cmd,
	output acs_pkg::acs_sts_t             sts,
	output logic                          granted,
	output logic                          stolen,
	output logic [TW-1:0]                 source_thread,
	output logic [ITER_BITS-1:0]          chunk_start,
	output logic [ITER_BITS-1:0]          chunk_end
);

	localparam int DW = CFG_W + 1;
	localparam int IW = ITER_BITS;

	// configuration
	logic [NTW-1:0] nt_q;
	logic [IW-1:0]  total_q;
	logic [NTW-1:0] nw_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_q    <= NTW'(4);
			total_q <= IW'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				acs_pkg::REG_NUM_THREADS: nt_q    <= cfg_wdata[NTW-1:0];
				acs_pkg::REG_TOTAL_ITER:  total_q <= cfg_wdata[IW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nt_q == '0) begin
			nw_eff = NTW'(1);
		end else if (nt_q > NTW'(MAX_WORKERS)) begin
			nw_eff = NTW'(MAX_WORKERS);
		end else begin
			nw_eff = nt_q;
		end
	end

	// working registers
	logic [TW-1:0] req_q;
	logic [TW-1:0] cnt_q;
	logic [TW-1:0] tgt_q;
	logic [TW-1:0] idx_s1;
	logic          rd_vld_s1;
	logic          loaded_q;
	logic [IW-1:0] rem_q;
	logic [IW-1:0] lim_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] cstart_q;

	// block table: {remaining, upper limit}
	logic            ram_we;
	logic [TW-1:0]   ram_waddr;
	logic [2*IW-1:0] ram_wdata;
	logic [TW-1:0]   ram_raddr;
	logic [2*IW-1:0] ram_rdata;
	logic [IW-1:0]   rd_rem;
	logic [IW-1:0]   rd_lim;

	acs_ram #(
		.WIDTH(2 * IW),
		.DEPTH(MAX_WORKERS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// table holds nothing useful until the first partition
	assign rd_rem = loaded_q ? ram_rdata[2*IW-1:IW] : '0;
	assign rd_lim = ram_rdata[IW-1:0];
	assign ram_raddr = cmd.own_rd ? req_q : cnt_q;

	// shared divider: ceil(x / workers) as (x + workers - 1) / workers
	logic          div_go;
	logic [DW-1:0] div_dividend;
	logic [DW-1:0] div_quo;
	logic [IW-1:0] quo;

	assign div_go = cmd.part_div | cmd.take_div;
	assign div_dividend = (cmd.part_div ? DW'(total_q) : DW'(rem_q)) + DW'(nw_eff) - DW'(1);

	acs_div #(
		.DW(DW),
		.VW(NTW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(div_dividend),
		.divisor (nw_eff),
		.done    (sts.div_done),
		.quotient(div_quo)
	);

	assign quo = div_quo[IW-1:0];

	// partition entry
	logic          part_in_range;
	logic [IW:0]   part_sum;
	logic [IW-1:0] part_hi;
	logic [IW-1:0] part_rem;

	assign part_in_range = NTW'(cnt_q) < nw_eff;
	assign part_sum = {1'b0, lo_q} + {1'b0, quo};
	assign part_hi  = (part_sum > {1'b0, total_q}) ? total_q : part_sum[IW-1:0];
	assign part_rem = part_hi - lo_q;

	// chunk end
	logic [IW:0]   take_sum;
	logic [IW-1:0] take_end;

	assign take_sum = {1'b0, cstart_q} + {1'b0, quo};
	assign take_end = (take_sum > {1'b0, lim_q}) ? lim_q : take_sum[IW-1:0];

	always_comb begin
		ram_we    = cmd.part_wr | cmd.take_wr;
		ram_waddr = cmd.take_wr ? tgt_q : cnt_q;
		if (cmd.take_wr) begin
			ram_wdata = {lim_q - take_end, lim_q};
		end else if (part_in_range) begin
			ram_wdata = {part_rem, part_hi};
		end else begin
			ram_wdata = '0;
		end
	end

	logic better;
	assign better = rd_vld_s1 && (rd_rem > rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.part_wr) begin
				loaded_q <= 1'b1;
			end
			if (cmd.part_div || cmd.scan_init) begin
				cnt_q <= '0;
			end else if (cmd.part_wr || cmd.scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.item_load) begin
			req_q <= requester_thread;
		end
		if (cmd.part_div) begin
			lo_q <= '0;
		end else if (cmd.part_wr && part_in_range) begin
			lo_q <= part_hi;
		end
		if (cmd.own_take) begin
			rem_q <= rd_rem;
			lim_q <= rd_lim;
			tgt_q <= req_q;
		end else if (cmd.scan_init) begin
			rem_q <= '0;
		end else if (cmd.scan_cmp && better) begin
			rem_q <= rd_rem;
			lim_q <= rd_lim;
			tgt_q <= idx_s1;
		end
		if (cmd.take_div) begin
			cstart_q <= (lim_q >= rem_q) ? lim_q - rem_q : '0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_clear) begin
			granted       <= 1'b0;
			stolen        <= 1'b0;
			source_thread <= '0;
			chunk_start   <= '0;
			chunk_end     <= '0;
		end else if (cmd.take_wr) begin
			granted       <= 1'b1;
			stolen        <= tgt_q != req_q;
			source_thread <= tgt_q;
			chunk_start   <= cstart_q;
			chunk_end     <= take_end;
		end
	end

	assign sts.req_in_range = NTW'(req_q) < nw_eff;
	assign sts.own_work     = rd_rem != '0;
	assign sts.scan_last    = NTW'(cnt_q) == nw_eff - NTW'(1);
	assign sts.part_last    = cnt_q == TW'(MAX_WORKERS - 1);
	assign sts.found        = (rem_q != '0) || (rd_vld_s1 && rd_rem != '0);

endmodule

// File: hw/rtl/acs_ctrl.sv
// Scheduler controller: sequences partition, own-block take and steal scan.
// Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              func,
	input  acs_pkg::acs_sts_t sts,
	output acs_pkg::acs_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_PART_WAIT = 11'b000_0000_0010,
		ST_PART_WR   = 11'b000_0000_0100,
		ST_OWN_RD    = 11'b000_0000_1000,
		ST_OWN_CHK   = 11'b000_0001_0000,
		ST_SCAN_RD   = 11'b000_0010_0000,
		ST_SCAN_LAST = 11'b000_0100_0000,
		ST_DIV_ISSUE = 11'b000_1000_0000,
		ST_DIV_WAIT  = 11'b001_0000_0000,
		ST_TAKE      = 11'b010_0000_0000,
		ST_REPLY     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.item_load = 1'b1;
					if (func == acs_pkg::FUNC_START) begin
						cmd.part_div = 1'b1;
						state_d      = ST_PART_WAIT;
					end else begin
						state_d = ST_OWN_RD;
					end
				end
			end
			ST_PART_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_PART_WR;
				end
			end
			ST_PART_WR: begin
				cmd.part_wr = 1'b1;
				if (sts.part_last) begin
					cmd.res_clear = 1'b1;
					state_d       = ST_REPLY;
				end
			end
			ST_OWN_RD: begin
				if (sts.req_in_range) begin
					cmd.own_rd = 1'b1;
					state_d    = ST_OWN_CHK;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_OWN_CHK: begin
				if (sts.own_work) begin
					cmd.own_take = 1'b1;
					state_d      = ST_DIV_ISSUE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_cmp = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: begin
				cmd.scan_cmp = 1'b1;
				if (sts.found) begin
					state_d = ST_DIV_ISSUE;
				end else begin
					cmd.res_clear = 1'b1;
					state_d       = ST_REPLY;
				end
			end
			ST_DIV_ISSUE: begin
				cmd.take_div = 1'b1;
				state_d      = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				cmd.take_wr = 1'b1;
				state_d     = ST_REPLY;
			end
			ST_REPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_REPLY;

endmodule

// File: hw/rtl/affinity_chunk_scheduler.sv
// Top level of the affinity chunk scheduler: controller plus datapath.
// Depends on acs_pkg, acs_ctrl, acs_datapath (and through it acs_ram, acs_div).
//
// channel  | handshake        | payload
// ---------+------------------+---------------------------------------------------
// item in  | start / busy     | func, requester_thread
// result   | done (1 cycle)   | granted, stolen, source_thread, chunk_start, chunk_end
// config   | cfg_we           | cfg_index, cfg_wdata
//
// A beat is taken when start is high and busy is low; one item is in work at a time.
// Start item: serial divide, then one table entry per cycle, from accept to result.
// Request: own block read, then a serial divide for the chunk size; the steal scan
// (one table read per cycle) comes before the divide when the own block is empty.
// The divider (one quotient bit per cycle) and the single table read port set the pace;
// busy drops the cycle after the result.
// Reset clears control and the table fill mark; no clearing pass is needed.
// done marks the result for exactly one cycle and cannot be held off.
`timescale 1ns / 1ps

module affinity_chunk_scheduler #(
	parameter int MAX_WORKERS = 16,
	parameter int ITER_BITS   = 16,
	localparam int TW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
	localparam int NTW   = $clog2(MAX_WORKERS + 1),
	localparam int CFG_W = (ITER_BITS > NTW) ? ITER_BITS : NTW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [TW-1:0]                 requester_thread,
	output logic                          done,
	output logic                          granted,
	output logic                          stolen,
	output logic [TW-1:0]                 source_thread,
	output logic [ITER_BITS-1:0]          chunk_start,
	output logic [ITER_BITS-1:0]          chunk_end,
	input  logic                          cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata
);

	acs_pkg::acs_cmd_t cmd;
	acs_pkg::acs_sts_t sts;

	acs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	acs_datapath #(
		.MAX_WORKERS(MAX_WORKERS),
		.ITER_BITS  (ITER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.requester_thread(requester_thread),
		.cmd             (cmd),
		.sts             (sts),
		.granted         (granted),
		.stolen          (stolen),
		.source_thread   (source_thread),
		.chunk_start     (chunk_start),
		.chunk_end       (chunk_end)
	);

endmodule

// File: hw/rtl/acs_checker.sv
// Port-level checks for the affinity chunk scheduler, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module acs_checker #(
	parameter int TW = 4,
	parameter int IW = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic          granted,
	input logic          stolen,
	input logic [TW-1:0] source_thread,
	input logic [IW-1:0] chunk_start,
	input logic [IW-1:0] chunk_end
);

	// an accepted beat keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting an item");

	// the result ends the item
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// a result without a grant carries an all-zero payload
	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |->
		(!stolen && source_thread == '0 && chunk_start == '0 && chunk_end == '0))
		else $error("no-grant result with nonzero fields");

	// a granted chunk is never empty
	a_grant_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> (chunk_end > chunk_start))
		else $error("granted chunk is empty");

endmodule

bind affinity_chunk_scheduler acs_checker #(
	.TW(TW),
	.IW(ITER_BITS)
) u_acs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.granted      (granted),
	.stolen       (stolen),
	.source_thread(source_thread),
	.chunk_start  (chunk_start),
	.chunk_end    (chunk_end)
);
